[hw/rtl/rpn_pkg.sv]
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared widths, operation and status codes, and the request and response
// types that pass between the sequencer and the arithmetic unit.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;
    localparam int LVL_W  = 8;

    // Operation codes. Codes above peek behave as peek.
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK = 3'd5;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_OVF  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNF  = 2'd2;
    localparam logic [ST_W-1:0] ST_DIV0 = 2'd3;

    typedef logic [DATA_W-1:0] word_t;

    // Start request to the arithmetic unit.
    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] op;
    } alu_req_t;

    // Completion from the arithmetic unit.
    typedef struct packed {
        logic  done;
        word_t result;
    } alu_rsp_t;

endpackage

[hw/rtl/rpn_cmd_if.sv]
// ----------------------------------------------------------------------------
// RPN command channel
// Valid/ready channel that carries one operation word into the calculator.
// ----------------------------------------------------------------------------
interface rpn_cmd_if
    import rpn_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

[hw/rtl/rpn_rsp_if.sv]
// ----------------------------------------------------------------------------
// RPN response channel
// Valid/ready channel that carries one result word out of the calculator.
// ----------------------------------------------------------------------------
interface rpn_rsp_if
    import rpn_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic [ST_W-1:0]          status;
    logic [LVL_W-1:0]         stack_level;

    modport source (output valid, output top_value, output status, output stack_level,
                    input ready);
    modport sink   (input valid, input top_value, input status, input stack_level,
                    output ready);
endinterface

[hw/rtl/rpn_stack_calculator_top.sv]
// ----------------------------------------------------------------------------
// RPN stack calculator
// Postfix calculator over a bounded stack of signed 32-bit words, with a
// stack memory, an operand fetch sequencer and a shared serial arithmetic unit.
//
//   Channel   Direction   Word contents
//   cmd       in          op, value
//   rsp       out         top_value, status, stack_level
//
// A push that fits goes straight from accept to the output stage; peek and a full
// push first pass the two registered stack memory reads. Arithmetic runs the
// 32 steps of the serial unit plus its load and fix-up.
// Reset clears the level and all control state; the stack memory is not cleared.
// A stalled result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_top
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    rpn_cmd_if.sink    cmd,
    rpn_rsp_if.source  rsp
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDA  = 3'd1;
    localparam logic [2:0] S_RDB  = 3'd2;
    localparam logic [2:0] S_CAPB = 3'd3;
    localparam logic [2:0] S_ALU  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;
    logic [OP_W-1:0] op_reg, op_next;
    word_t           a_reg, a_next;
    word_t           b_reg, b_next;
    word_t           res_reg, res_next;
    logic [ST_W-1:0] st_reg, st_next;
    word_t           out_top_reg, out_top_next;
    logic [ST_W-1:0] out_st_reg, out_st_next;
    logic [CW-1:0]   out_lvl_reg, out_lvl_next;

    word_t           mem [STACK_DEPTH];
    word_t           rdata_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    word_t           mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;

    alu_req_t        alu_req;
    alu_rsp_t        alu_rsp;

    logic            cmd_fire;
    logic            has_one;
    logic            has_two;
    logic            is_binop;
    logic            div_zero;
    word_t           alu_word;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign has_one  = (cnt_reg != '0);
    assign has_two  = (cnt_reg >= CW'(2));
    assign is_binop = (op_reg == OP_ADD) || (op_reg == OP_SUB)
                      || (op_reg == OP_MUL) || (op_reg == OP_DIV);
    assign div_zero = (op_reg == OP_DIV) && (a_reg == '0);
    assign alu_word = div_zero ? '0 : alu_rsp.result;

    // Serial arithmetic unit. The second operand is loaded in the same cycle
    // that it leaves the memory, so the unit takes it before it is registered.
    rpn_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .opnd_a (a_reg),
        .opnd_b (b_next),
        .rsp    (alu_rsp)
    );

    // Sequencer: fetch operands, run the unit, write back, hand off the result.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        out_top_next   = out_top_reg;
        out_st_next    = out_st_reg;
        out_lvl_next   = out_lvl_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = AW'(cnt_reg);
        mem_wdata      = cmd.value;
        mem_re         = 1'b0;
        mem_raddr      = AW'(cnt_reg - CW'(1));
        alu_req.start  = 1'b0;
        alu_req.op     = op_reg;

        // The output word leaves when the sink takes it.
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next  = cmd.op;
                    if ((cmd.op == OP_PUSH) && (cnt_reg < CW'(STACK_DEPTH)))
                    begin
                        mem_we     = 1'b1;
                        cnt_next   = cnt_reg + CW'(1);
                        res_next   = cmd.value;
                        st_next    = ST_OK;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RDA;
                    end
                end
            end
            S_RDA:
            begin
                mem_re     = has_one;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                a_next     = has_one ? rdata_reg : '0;
                mem_re     = has_two;
                mem_raddr  = AW'(cnt_reg - CW'(2));
                state_next = S_CAPB;
            end
            S_CAPB:
            begin
                b_next = has_two ? rdata_reg : '0;
                priority if (op_reg == OP_PUSH)
                begin
                    // Full stack: the push is dropped and the top is shown.
                    res_next   = a_reg;
                    st_next    = ST_OVF;
                    state_next = S_OUT;
                end
                else if (is_binop)
                begin
                    alu_req.start = 1'b1;
                    state_next    = S_ALU;
                end
                else
                begin
                    // Peek pops and pushes back; an empty stack gains a zero.
                    res_next = a_reg;
                    if (has_one)
                    begin
                        st_next = ST_OK;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = '0;
                        cnt_next  = CW'(1);
                        st_next   = ST_UNF;
                    end
                    state_next = S_OUT;
                end
            end
            S_ALU:
            begin
                if (alu_rsp.done)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = alu_word;
                    res_next  = alu_word;
                    if (has_two)
                    begin
                        mem_waddr = AW'(cnt_reg - CW'(2));
                        cnt_next  = cnt_reg - CW'(1);
                    end
                    else
                    begin
                        mem_waddr = '0;
                        cnt_next  = CW'(1);
                    end
                    priority if (!has_two)
                    begin
                        st_next = ST_UNF;
                    end
                    else if (div_zero)
                    begin
                        st_next = ST_DIV0;
                    end
                    else
                    begin
                        st_next = ST_OK;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_top_next   = res_reg;
                    out_st_next    = st_reg;
                    out_lvl_next   = cnt_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        res_reg     <= res_next;
        st_reg      <= st_next;
        out_top_reg <= out_top_next;
        out_st_reg  <= out_st_next;
        out_lvl_reg <= out_lvl_next;
    end

    // Stack memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Channel outputs.
    assign cmd.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.top_value   = out_top_reg;
    assign rsp.status      = out_st_reg;
    assign rsp.stack_level = LVL_W'(out_lvl_reg);

    // The level never passes the stack depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack level above depth");

    // A push that fits raises the level by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && (cmd.op == OP_PUSH) && (cnt_reg < CW'(STACK_DEPTH))
        |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("push did not raise the level");

    // The arithmetic unit finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> state_reg == S_ALU)
        else $error("unexpected arithmetic completion");

    // A binary operation on two or more entries lowers the level by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALU) && alu_rsp.done && has_two
        |=> cnt_reg == $past(cnt_reg) - CW'(1))
        else $error("binary operation left a wrong level");

endmodule

[hw/rtl/rpn_alu.sv]
// ----------------------------------------------------------------------------
// RPN arithmetic unit
// Shared serial unit: add and subtract go one bit per cycle through shift
// registers, multiply is shift-and-add over the multiplier bits, and divide
// is restoring division with one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_alu
    import rpn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    input  word_t    opnd_a,
    input  word_t    opnd_b,
    output alu_rsp_t rsp
);

    localparam int STEP_W = $clog2(DATA_W);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_FIX  = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [OP_W-1:0]   op_reg, op_next;
    word_t             x_reg, x_next;
    word_t             y_reg, y_next;
    word_t             acc_reg, acc_next;
    word_t             rem_reg, rem_next;
    word_t             res_reg, res_next;
    logic              carry_reg, carry_next;
    logic              neg_reg, neg_next;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              fits;
    logic              a_bit;
    logic              s_bit;

    // Restoring division step: bring down the next dividend bit and try x.
    assign trial = {rem_reg, y_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, x_reg};
    assign fits  = (trial >= {1'b0, x_reg});

    // Serial full adder; the subtrahend is inverted and the carry starts at one.
    assign a_bit = x_reg[0] ^ (op_reg == OP_SUB);
    assign s_bit = y_reg[0] ^ a_bit ^ carry_reg;

    // Next-state logic of the unit.
    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        op_next    = op_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        carry_next = carry_reg;
        neg_next   = neg_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    step_next  = '0;
                    carry_next = (req.op == OP_SUB);
                    acc_next   = '0;
                    rem_next   = '0;
                    neg_next   = opnd_a[DATA_W-1] ^ opnd_b[DATA_W-1];
                    if (req.op == OP_DIV)
                    begin
                        x_next = opnd_a[DATA_W-1] ? (~opnd_a + 1'b1) : opnd_a;
                        y_next = opnd_b[DATA_W-1] ? (~opnd_b + 1'b1) : opnd_b;
                    end
                    else
                    begin
                        x_next = opnd_a;
                        y_next = opnd_b;
                    end
                    phase_next = PH_RUN;
                end
            end
            PH_RUN:
            begin
                priority if (op_reg == OP_MUL)
                begin
                    acc_next = acc_reg + (x_reg[0] ? y_reg : '0);
                    x_next   = x_reg >> 1;
                    y_next   = y_reg << 1;
                end
                else if (op_reg == OP_DIV)
                begin
                    rem_next = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
                    y_next   = {y_reg[DATA_W-2:0], fits};
                end
                else
                begin
                    acc_next   = {s_bit, acc_reg[DATA_W-1:1]};
                    carry_next = (y_reg[0] & a_bit) | (y_reg[0] & carry_reg)
                                 | (a_bit & carry_reg);
                    x_next     = x_reg >> 1;
                    y_next     = y_reg >> 1;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DATA_W - 1))
                begin
                    phase_next = PH_FIX;
                end
            end
            PH_FIX:
            begin
                // Quotient sign fix-up, or hand over the accumulated word.
                if (op_reg == OP_DIV)
                begin
                    res_next = neg_reg ? (~y_reg + 1'b1) : y_reg;
                end
                else
                begin
                    res_next = acc_reg;
                end
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        res_reg   <= res_next;
        carry_reg <= carry_next;
        neg_reg   <= neg_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

[tb/rpn_stack_calculator_top_tb.sv]
// ----------------------------------------------------------------------------
// RPN stack calculator testbench
// Drives command words into the calculator and checks every response word
// against a predictor kept in step with the stack. Directed cases cover the
// empty and full stack, underflow and divide by zero, and the arithmetic
// corner values. A fill-and-drain pass, a long output hold-off, a run with no
// idling and a random mix of mostly well-formed expressions follow.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_top_tb
    import rpn_pkg::*;
;

    localparam int STACK_DEPTH    = 128;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int HOLD_OFF_LEN   = 150;

    // Spare operation codes; the block treats them as peek.
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        word_t            top_value;
        logic [ST_W-1:0]  status;
        logic [LVL_W-1:0] stack_level;
    } calc_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rpn_cmd_if cmd_if ();
    rpn_rsp_if rsp_if ();

    rpn_stack_calculator_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    // Predicted stack contents and level.
    word_t        calc_store [STACK_DEPTH];
    int unsigned  calc_level;
    calc_result_t pending_results [$];

    int unsigned failures     = 0;
    bit          idle_on      = 1'b1;
    int unsigned hold_request = 0;
    int unsigned hold_left    = 0;
    int unsigned rsp_stall    = 0;
    int unsigned quiet_cycles = 0;

    always #4 clk = ~clk;

    // Pop one entry; an empty stack reads as zero.
    function automatic bit calc_pop(output word_t v);
        if (calc_level == 0)
        begin
            v = '0;
            return 1'b0;
        end
        calc_level--;
        v = calc_store[calc_level];
        return 1'b1;
    endfunction

    function automatic void calc_push(input word_t v);
        if (calc_level < STACK_DEPTH)
        begin
            calc_store[calc_level] = v;
            calc_level++;
        end
    endfunction

    // Signed division that truncates toward zero and wraps on overflow.
    function automatic word_t calc_quotient(input word_t b, input word_t a);
        word_t mag_b;
        word_t mag_a;
        word_t q;
        mag_b = b[DATA_W-1] ? -b : b;
        mag_a = a[DATA_W-1] ? -a : a;
        q     = mag_b / mag_a;
        return (b[DATA_W-1] != a[DATA_W-1]) ? -q : q;
    endfunction

    // Apply one command word to the predicted stack and return its response.
    function automatic calc_result_t calc_apply(input logic [OP_W-1:0] op, input word_t value);
        word_t           a;
        word_t           b;
        word_t           res;
        bit              got_a;
        bit              got_b;
        logic [ST_W-1:0] st;
        calc_result_t    r;
        st = ST_OK;
        if (op == OP_PUSH)
        begin
            if (calc_level < STACK_DEPTH)
            begin
                calc_push(value);
                res = value;
            end
            else
            begin
                res = calc_store[calc_level - 1];
                st  = ST_OVF;
            end
        end
        else if (op >= OP_ADD && op <= OP_DIV)
        begin
            got_a = calc_pop(a);
            got_b = calc_pop(b);
            case (op)
                OP_ADD: res = b + a;
                OP_SUB: res = b - a;
                OP_MUL: res = b * a;
                default:
                begin
                    if (a == '0)
                    begin
                        res = '0;
                        st  = ST_DIV0;
                    end
                    else
                    begin
                        res = calc_quotient(b, a);
                    end
                end
            endcase
            // Underflow wins over divide by zero.
            if (!got_a || !got_b)
                st = ST_UNF;
            calc_push(res);
        end
        else
        begin
            if (!calc_pop(res))
                st = ST_UNF;
            calc_push(res);
        end
        r.top_value   = res;
        r.status      = st;
        r.stack_level = calc_level[LVL_W-1:0];
        return r;
    endfunction

    // Operand values weighted toward the extremes and small numbers.
    function automatic word_t rand_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3, 4:    return $urandom_range(0, 32) - 16;
            default: return $urandom();
        endcase
    endfunction

    // Send one command word and record its expected response on acceptance.
    task automatic send_word(input logic [OP_W-1:0] op, input word_t value);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid = 1'b1;
        cmd_if.op    = op;
        cmd_if.value = value;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        pending_results.push_back(calc_apply(op, value));
    endtask

    // Mostly well-formed expressions: pushes and operations in balance.
    task automatic send_random_word();
        logic [OP_W-1:0] op;
        int unsigned     pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = OP_PUSH;
        else if (pick < 90)
            op = OP_ADD + OP_W'(pick % 4);
        else
            op = OP_PEEK + OP_W'(pick % 3);
        if (calc_level < 2 && pick < 80)
            op = OP_PUSH;
        send_word(op, rand_operand());
    endtask

    // Empty stack, underflow, divide by zero and arithmetic corner values.
    task automatic test_edge_cases();
        send_word(OP_PEEK, 32'h1234_5678);
        send_word(OP_DIV, $urandom());
        send_word(OP_ADD, $urandom());
        send_word(OP_PUSH, 32'h8000_0000);
        send_word(OP_PUSH, 32'hFFFF_FFFF);
        send_word(OP_DIV, '0);
        send_word(OP_PUSH, 32'd7);
        send_word(OP_PUSH, '0);
        send_word(OP_DIV, '0);
        send_word(OP_PUSH, -32'sd7);
        send_word(OP_PUSH, 32'd2);
        send_word(OP_DIV, '0);
        send_word(OP_PUSH, 32'h7FFF_FFFF);
        send_word(OP_PUSH, 32'd1);
        send_word(OP_ADD, '0);
        send_word(OP_PUSH, 32'd5);
        send_word(OP_PUSH, 32'd9);
        send_word(OP_SUB, '0);
        send_word(OP_PUSH, 32'h0001_0000);
        send_word(OP_PUSH, 32'h0001_0003);
        send_word(OP_MUL, '0);
        send_word(OP_SPARE_6, $urandom());
        send_word(OP_SPARE_7, $urandom());
    endtask

    // Fill the stack, push past the top, peek, then drain it to three entries with operations.
    task automatic test_fill_and_overflow();
        while (calc_level < STACK_DEPTH)
            send_word(OP_PUSH, rand_operand());
        repeat (3) send_word(OP_PUSH, rand_operand());
        send_word(OP_PEEK, $urandom());
        while (calc_level > 3)
            send_word(OP_ADD + OP_W'($urandom_range(0, 3)), rand_operand());
    endtask

    // Hold the response side off while command words keep coming.
    task automatic test_output_hold_off();
        hold_request = HOLD_OFF_LEN;
        repeat (10) send_word(OP_PUSH, rand_operand());
        send_word(OP_MUL, '0);
        send_word(OP_PEEK, '0);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (100) send_random_word();
        idle_on = 1'b1;
    endtask

    task automatic test_random_mix();
        repeat (450) send_random_word();
    endtask

    // Response ready: long hold-off first, then per-word stalls.
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                rsp_if.ready = 1'b0;
                hold_left--;
            end
            else if (rsp_stall > 0)
            begin
                rsp_if.ready = 1'b0;
                rsp_stall--;
            end
            else
            begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    // Compare each response word with the oldest expectation.
    always @(posedge clk)
    begin
        calc_result_t want;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            rsp_stall = idle_on ? $urandom_range(0, 5) : 0;
            if (pending_results.size() == 0)
            begin
                $error("unexpected response word: top_value %0d status %0d stack_level %0d",
                       rsp_if.top_value, rsp_if.status, rsp_if.stack_level);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.top_value !== want.top_value)
                begin
                    $error("top_value: expected %0d, actual %0d",
                           $signed(want.top_value), rsp_if.top_value);
                    failures++;
                end
                if (rsp_if.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                    failures++;
                end
                if (rsp_if.stack_level !== want.stack_level)
                begin
                    $error("stack_level: expected %0d, actual %0d",
                           want.stack_level, rsp_if.stack_level);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles where neither channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        cmd_if.valid = 1'b0;
        cmd_if.op    = OP_PUSH;
        cmd_if.value = '0;
        calc_level   = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_edge_cases();
        test_fill_and_overflow();
        test_output_hold_off();
        test_back_to_back();
        test_random_mix();

        @(negedge clk);
        cmd_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && pending_results.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
